FILE: rtl/spc_pkg.sv
// ----------------------------------------------------------------------------
// spc_pkg: shared types and constants of the stream pattern censor
// Field widths, hash constants, opcodes, register indexes and the structs
// that pass between the sequencer, the register block and the multiplier.
// ----------------------------------------------------------------------------
package spc_pkg;

    // Sizes
    localparam int STACK_DEPTH_DEF = 4096;
    localparam int HASH_W          = 30;
    localparam int CHAR_W          = 8;
    localparam int IDX_W           = 12;
    localparam int LEN_W           = 13;
    localparam int APB_AW          = 4;
    localparam int APB_DW          = 32;
    localparam int CNT_W           = $clog2(HASH_W);

    // Hash constants
    localparam logic [HASH_W-1:0] HASH_MOD          = 30'd998244353;
    localparam logic [HASH_W-1:0] HASH_BASE         = 30'd13331;
    localparam int                HASH_BASE_W       = 14;
    localparam logic [HASH_W-1:0] HASH_BASE_ALIGNED = HASH_BASE << (HASH_W - HASH_BASE_W);

    // Opcodes
    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_READ = 1'b1;

    // Register indexes
    localparam logic [1:0] REG_PAT_LEN   = 2'd0;
    localparam logic [1:0] REG_PAT_HASH  = 2'd1;
    localparam logic [1:0] REG_PAT_POWER = 2'd2;

    typedef struct packed {
        logic [LEN_W-1:0]  pat_len;
        logic [HASH_W-1:0] pat_hash;
        logic [HASH_W-1:0] pat_power;
    } t_cfg;

    // Multiplier request: b is MSB-aligned, last is the step count minus one
    typedef struct packed {
        logic              start;
        logic [HASH_W-1:0] a;
        logic [HASH_W-1:0] b;
        logic [CNT_W-1:0]  last;
    } t_mul_req;

    typedef struct packed {
        logic              done;
        logic [HASH_W-1:0] prod;
    } t_mul_rsp;

    // Reduce a value below twice the modulus
    function automatic logic [HASH_W-1:0] mod_fold(input logic [HASH_W:0] x);
        logic [HASH_W:0] t;
        t = (x >= {1'b0, HASH_MOD}) ? x - {1'b0, HASH_MOD} : x;
        return t[HASH_W-1:0];
    endfunction

endpackage

FILE: rtl/spc_if.sv
// ----------------------------------------------------------------------------
// spc_if: stream channels of the stream pattern censor
// Input channel carries one command word, output channel one result word.
// ----------------------------------------------------------------------------
interface spc_in_if;
    logic                         valid;
    logic                         ready;
    logic                         opcode;
    logic [spc_pkg::CHAR_W-1:0]   text_char;
    logic [spc_pkg::IDX_W-1:0]    read_index;

    modport source (output valid, output opcode, output text_char, output read_index,
                    input ready);
    modport sink   (input valid, input opcode, input text_char, input read_index,
                    output ready);
endinterface

interface spc_out_if;
    logic                         valid;
    logic                         ready;
    logic                         matched;
    logic [spc_pkg::LEN_W-1:0]    text_length;
    logic [spc_pkg::CHAR_W-1:0]   read_char;
    logic                         overflow;
    logic                         bad_index;

    modport source (output valid, output matched, output text_length, output read_char,
                    output overflow, output bad_index, input ready);
    modport sink   (input valid, input matched, input text_length, input read_char,
                    input overflow, input bad_index, output ready);
endinterface

FILE: rtl/spc_ram.sv
// ----------------------------------------------------------------------------
// spc_ram: generic single-write, single-read RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module spc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/spc_cfg.sv
// ----------------------------------------------------------------------------
// spc_cfg: APB register block
// Holds pattern length, pattern hash and pattern power; zero-wait writes.
// ----------------------------------------------------------------------------
module spc_cfg (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [spc_pkg::APB_AW-1:0]   paddr,
    input  logic [spc_pkg::APB_DW-1:0]   pwdata,
    output logic [spc_pkg::APB_DW-1:0]   prdata,
    output logic                         pready,
    output spc_pkg::t_cfg                o_cfg
);

    spc_pkg::t_cfg r_cfg;
    logic          wr_en;
    logic [1:0]    reg_idx;

    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[3:2];
    assign pready  = 1'b1;

    // Write registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pat_len   <= spc_pkg::LEN_W'(1);
            r_cfg.pat_hash  <= '0;
            r_cfg.pat_power <= spc_pkg::HASH_W'(1);
        end else if (wr_en) begin
            unique case (reg_idx)
                spc_pkg::REG_PAT_LEN:   r_cfg.pat_len   <= pwdata[spc_pkg::LEN_W-1:0];
                spc_pkg::REG_PAT_HASH:  r_cfg.pat_hash  <= pwdata[spc_pkg::HASH_W-1:0];
                spc_pkg::REG_PAT_POWER: r_cfg.pat_power <= pwdata[spc_pkg::HASH_W-1:0];
                default: ;
            endcase
        end
    end

    // Read back
    always_comb begin
        unique case (reg_idx)
            spc_pkg::REG_PAT_LEN:   prdata = spc_pkg::APB_DW'(r_cfg.pat_len);
            spc_pkg::REG_PAT_HASH:  prdata = spc_pkg::APB_DW'(r_cfg.pat_hash);
            spc_pkg::REG_PAT_POWER: prdata = spc_pkg::APB_DW'(r_cfg.pat_power);
            default:                prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

FILE: rtl/spc_modmul.sv
// ----------------------------------------------------------------------------
// spc_modmul: shared serial modular multiplier
// Double-and-add over the bits of b, MSB first, one bit per cycle, keeping
// the accumulator below the hash modulus. Both operands must be reduced.
// ----------------------------------------------------------------------------
module spc_modmul (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  spc_pkg::t_mul_req i_req,
    output spc_pkg::t_mul_rsp o_rsp
);

    logic                        r_busy;
    logic                        r_done;
    logic [spc_pkg::CNT_W-1:0]   r_cnt;
    logic [spc_pkg::HASH_W-1:0]  r_acc;
    logic [spc_pkg::HASH_W-1:0]  r_a;
    logic [spc_pkg::HASH_W-1:0]  r_b;
    logic [spc_pkg::HASH_W-1:0]  dbl;
    logic [spc_pkg::HASH_W-1:0]  addend;
    logic [spc_pkg::HASH_W-1:0]  n_acc;

    // One step: acc = 2*acc + bit*a, both folded into range
    always_comb begin
        dbl    = spc_pkg::mod_fold({r_acc, 1'b0});
        addend = r_b[spc_pkg::HASH_W-1] ? r_a : '0;
        n_acc  = spc_pkg::mod_fold({1'b0, dbl} + {1'b0, addend});
    end

    // Step counter and done pulse
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_req.last;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Operands and accumulator
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_acc <= '0;
            r_a   <= i_req.a;
            r_b   <= i_req.b;
        end else if (r_busy) begin
            r_acc <= n_acc;
            r_b   <= r_b << 1;
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.prod = r_acc;

endmodule

FILE: rtl/stream_pattern_censor.sv
// ----------------------------------------------------------------------------
// stream_pattern_censor: text stack with rolling-hash pattern removal
// From accept to result valid: a push runs the multiplier, twice with a hash
// compare; a read waits for the RAM read; overflow or bad index go straight on.
// One word in flight; the next word is taken the cycle after the result leaves.
// The push time is set by the shared serial multiplier (14 then 30 steps).
// Synchronous reset empties the stack; no memory clearing pass is needed.
// ----------------------------------------------------------------------------
module stream_pattern_censor #(
    parameter int STACK_DEPTH = spc_pkg::STACK_DEPTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    spc_in_if.sink                       i_in,
    spc_out_if.source                    o_out,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [spc_pkg::APB_AW-1:0]   paddr,
    input  logic [spc_pkg::APB_DW-1:0]   pwdata,
    output logic [spc_pkg::APB_DW-1:0]   prdata,
    output logic                         pready
);

    localparam int LW = $clog2(STACK_DEPTH + 1);
    localparam int AW = $clog2(STACK_DEPTH);
    localparam int WW = ((LW > spc_pkg::LEN_W) ? LW : spc_pkg::LEN_W) + 1;
    localparam int CW = (LW > spc_pkg::IDX_W) ? LW : spc_pkg::IDX_W;
    localparam int HW = spc_pkg::HASH_W;

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_MUL_H   = 3'd1;
    localparam logic [2:0] S_ADD_C   = 3'd2;
    localparam logic [2:0] S_MUL_S   = 3'd3;
    localparam logic [2:0] S_CMP     = 3'd4;
    localparam logic [2:0] S_RD_WAIT = 3'd5;
    localparam logic [2:0] S_DONE    = 3'd6;

    logic [2:0]                  r_state;
    logic [2:0]                  n_state;
    logic [LW-1:0]               r_len;
    logic [HW-1:0]               r_top;
    logic [HW-1:0]               r_h;
    logic [HW-1:0]               r_old;
    logic [spc_pkg::CHAR_W-1:0]  r_c;
    logic [spc_pkg::CHAR_W-1:0]  r_rchar;
    logic                        r_matched;
    logic                        r_ovf;
    logic                        r_bad;

    spc_pkg::t_cfg               cfg;
    spc_pkg::t_mul_req           mul_req;
    spc_pkg::t_mul_rsp           mul_rsp;

    logic                        accept_in;
    logic                        is_push;
    logic                        full;
    logic [WW-1:0]               len_inc_w;
    logic [WW-1:0]               m_w;
    logic [WW-1:0]               base_w;
    logic [WW-1:0]               len_dec_w;
    logic                        haddr_zero;
    logic                        check;
    logic [CW-1:0]               idx_w;
    logic                        idx_ok;
    logic [HW-1:0]               pw_red;
    logic [HW-1:0]               hsum;
    logic [HW:0]                 diff_w;
    logic                        hit;
    logic                        char_we;
    logic [spc_pkg::CHAR_W-1:0]  char_rdata;
    logic [HW-1:0]               hash_rdata;

    // Register block
    spc_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // Stack address arithmetic
    always_comb begin
        accept_in  = i_in.valid && i_in.ready;
        is_push    = (i_in.opcode == spc_pkg::OP_PUSH);
        full       = (r_len == LW'(STACK_DEPTH));
        len_inc_w  = WW'(r_len) + WW'(1);
        m_w        = WW'(cfg.pat_len);
        base_w     = len_inc_w - m_w;
        len_dec_w  = WW'(r_len) - m_w;
        haddr_zero = (base_w == '0);
        check      = (cfg.pat_len != '0) && (len_inc_w >= m_w);
        idx_w      = CW'(i_in.read_index);
        idx_ok     = idx_w < CW'(r_len);
        char_we    = accept_in && is_push && !full;
    end

    // Hash arithmetic around the multiplier
    always_comb begin
        pw_red = spc_pkg::mod_fold({1'b0, cfg.pat_power});
        hsum   = spc_pkg::mod_fold({1'b0, mul_rsp.prod} + (HW + 1)'(r_c));
        if (r_h >= mul_rsp.prod) begin
            diff_w = {1'b0, r_h} - {1'b0, mul_rsp.prod};
        end else begin
            diff_w = {1'b0, r_h} + {1'b0, spc_pkg::HASH_MOD} - {1'b0, mul_rsp.prod};
        end
        hit = (diff_w[HW-1:0] == cfg.pat_hash);
    end

    // Multiplier requests: top hash times base, then power times old prefix
    always_comb begin
        mul_req.start = 1'b0;
        mul_req.a     = r_top;
        mul_req.b     = spc_pkg::HASH_BASE_ALIGNED;
        mul_req.last  = spc_pkg::CNT_W'(spc_pkg::HASH_BASE_W - 1);
        if (r_state == S_IDLE) begin
            mul_req.start = char_we;
        end else if (r_state == S_ADD_C) begin
            mul_req.start = check;
            mul_req.a     = pw_red;
            mul_req.b     = r_old;
            mul_req.last  = spc_pkg::CNT_W'(HW - 1);
        end
    end

    spc_modmul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mul_req),
        .o_rsp   (mul_rsp)
    );

    // Character stack
    spc_ram #(
        .WIDTH (spc_pkg::CHAR_W),
        .DEPTH (STACK_DEPTH)
    ) u_char_ram (
        .i_clk   (i_clk),
        .i_we    (char_we),
        .i_waddr (r_len[AW-1:0]),
        .i_wdata (i_in.text_char),
        .i_raddr (idx_w[AW-1:0]),
        .o_rdata (char_rdata)
    );

    // Prefix hash stack; entry zero is never written and a read of it is replaced by zero
    spc_ram #(
        .WIDTH (HW),
        .DEPTH (STACK_DEPTH + 1)
    ) u_hash_ram (
        .i_clk   (i_clk),
        .i_we    (r_state == S_ADD_C),
        .i_waddr (len_inc_w[LW-1:0]),
        .i_wdata (hsum),
        .i_raddr (base_w[LW-1:0]),
        .o_rdata (hash_rdata)
    );

    // Sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept_in) begin
                    if (is_push) begin
                        n_state = full ? S_DONE : S_MUL_H;
                    end else begin
                        n_state = idx_ok ? S_RD_WAIT : S_DONE;
                    end
                end
            end
            S_MUL_H: begin
                if (mul_rsp.done) begin
                    n_state = S_ADD_C;
                end
            end
            S_ADD_C: begin
                n_state = check ? S_MUL_S : S_DONE;
            end
            S_MUL_S: begin
                if (mul_rsp.done) begin
                    n_state = S_CMP;
                end
            end
            S_CMP:     n_state = S_DONE;
            S_RD_WAIT: n_state = S_DONE;
            S_DONE: begin
                if (o_out.ready) begin
                    n_state = S_IDLE;
                end
            end
            default:   n_state = S_IDLE;
        endcase
    end

    // Advance state, stack length and top prefix hash
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_len   <= '0;
            r_top   <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_ADD_C) begin
                r_len <= len_inc_w[LW-1:0];
                r_top <= hsum;
            end else if (r_state == S_CMP && hit) begin
                r_len <= len_dec_w[LW-1:0];
                r_top <= r_old;
            end
        end
    end

    // Hold operands and result word fields
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (accept_in) begin
                    r_c       <= i_in.text_char;
                    r_matched <= 1'b0;
                    r_rchar   <= '0;
                    r_ovf     <= is_push && full;
                    r_bad     <= !is_push && !idx_ok;
                end
            end
            S_MUL_H: begin
                if (mul_rsp.done) begin
                    r_old <= haddr_zero ? '0 : hash_rdata;
                end
            end
            S_ADD_C:   r_h       <= hsum;
            S_CMP:     r_matched <= hit;
            S_RD_WAIT: r_rchar   <= char_rdata;
            default: ;
        endcase
    end

    assign i_in.ready        = (r_state == S_IDLE);
    assign o_out.valid       = (r_state == S_DONE);
    assign o_out.matched     = r_matched;
    assign o_out.text_length = spc_pkg::LEN_W'(r_len);
    assign o_out.read_char   = r_rchar;
    assign o_out.overflow    = r_ovf;
    assign o_out.bad_index   = r_bad;

    // An overflow result is only given with a full stack
    a_ovf_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.overflow |-> full)
        else $error("overflow reported with room on the stack");

    // The multiplier finishes only while the sequencer waits for it
    a_mul_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mul_rsp.done |-> (r_state == S_MUL_H || r_state == S_MUL_S))
        else $error("multiplier done outside a wait state");

    // The top prefix hash stays reduced
    a_top_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_top < spc_pkg::HASH_MOD)
        else $error("top prefix hash not reduced");

    // A match drops exactly the pattern length
    a_match_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CMP) && hit |=> (WW'(r_len) + $past(m_w) == WW'($past(r_len))))
        else $error("match removed the wrong number of characters");

endmodule

FILE: tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for stream_pattern_censor
// Streams push and read words through the block under four idling mixes and
// programs the pattern registers over APB between phases. A scoreboard keeps
// its own text stack and prefix hashes, predicts every result word and
// compares it field by field. Also covers a pattern longer than the stack.
// ----------------------------------------------------------------------------
module tb;
    import spc_pkg::*;

    localparam int          CLK_PERIOD   = 10;
    localparam int          LIMIT_CYCLES = 2_000_000;
    localparam int          TEXT_ITEMS   = 300;
    localparam bit [63:0]   MOD_64       = 64'(HASH_MOD);
    localparam bit [63:0]   BASE_64      = 64'(HASH_BASE);

    typedef struct packed {
        logic              matched;
        logic [LEN_W-1:0]  text_length;
        logic [CHAR_W-1:0] read_char;
        logic              overflow;
        logic              bad_index;
    } censor_result_t;

    // Text stack, prefix hashes and pattern registers as the block should hold them
    class censor_scoreboard;
        bit [CHAR_W-1:0]  text_mem [STACK_DEPTH_DEF];
        bit [HASH_W-1:0]  prefix_mem [STACK_DEPTH_DEF+1];
        int unsigned      depth;
        bit [LEN_W-1:0]   pat_len;
        bit [HASH_W-1:0]  pat_hash;
        bit [HASH_W-1:0]  pat_power;
        censor_result_t   expected_q[$];
        int               errors;

        function new();
            depth         = 0;
            prefix_mem[0] = '0;
            pat_len       = 1;
            pat_hash      = '0;
            pat_power     = 1;
            errors        = 0;
        endfunction

        // Apply a register write, return the value a read should give back
        function bit [APB_DW-1:0] write_reg(bit [1:0] idx, bit [APB_DW-1:0] value);
            case (idx)
                REG_PAT_LEN: begin
                    pat_len = value[LEN_W-1:0];
                    return APB_DW'(pat_len);
                end
                REG_PAT_HASH: begin
                    pat_hash = value[HASH_W-1:0];
                    return APB_DW'(pat_hash);
                end
                REG_PAT_POWER: begin
                    pat_power = value[HASH_W-1:0];
                    return APB_DW'(pat_power);
                end
                default: return '0;
            endcase
        endfunction

        // Advance the stack by one accepted word and queue the result it causes
        function void note_word(logic op, logic [CHAR_W-1:0] ch, logic [IDX_W-1:0] idx);
            censor_result_t r;
            bit [63:0]      h;
            bit [63:0]      sub;
            bit [63:0]      top;
            r = '0;
            if (op == OP_PUSH) begin
                if (depth >= STACK_DEPTH_DEF) begin
                    r.overflow = 1'b1;
                end else begin
                    h = (64'(prefix_mem[depth]) * BASE_64 + 64'(ch)) % MOD_64;
                    text_mem[depth]       = ch;
                    prefix_mem[depth + 1] = h[HASH_W-1:0];
                    depth++;
                    if (pat_len != 0 && depth >= pat_len) begin
                        // hash of the top pat_len characters
                        sub = ((64'(pat_power) % MOD_64) *
                               64'(prefix_mem[depth - pat_len])) % MOD_64;
                        top = (64'(prefix_mem[depth]) + MOD_64 - sub) % MOD_64;
                        if (top == 64'(pat_hash)) begin
                            depth     = depth - pat_len;
                            r.matched = 1'b1;
                        end
                    end
                end
            end else if (idx < depth) begin
                r.read_char = text_mem[idx];
            end else begin
                r.bad_index = 1'b1;
            end
            r.text_length = LEN_W'(depth);
            expected_q.insert(expected_q.size(), r);
        endfunction

        task report(string what, longint unsigned got, longint unsigned want);
            errors++;
            if (errors <= 40) begin
                $display("mismatch: %s got %0d expected %0d", what, got, want);
            end
        endtask

        // Compare one result word against the oldest prediction
        task check_result(censor_result_t got);
            censor_result_t want;
            if (expected_q.size() == 0) begin
                report("unexpected result word", 1, 0);
                return;
            end
            want = expected_q.pop_front();
            if (got.matched !== want.matched) begin
                report("matched", got.matched, want.matched);
            end
            if (got.text_length !== want.text_length) begin
                report("text_length", got.text_length, want.text_length);
            end
            if (got.read_char !== want.read_char) begin
                report("read_char", got.read_char, want.read_char);
            end
            if (got.overflow !== want.overflow) begin
                report("overflow", got.overflow, want.overflow);
            end
            if (got.bad_index !== want.bad_index) begin
                report("bad_index", got.bad_index, want.bad_index);
            end
        endtask
    endclass

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [APB_AW-1:0]    paddr;
    logic [APB_DW-1:0]    pwdata;
    logic [APB_DW-1:0]    prdata;
    logic                 pready;

    spc_in_if  in_if();
    spc_out_if out_if();

    censor_scoreboard     sb = new();
    bit [CHAR_W-1:0]      pattern_q[$];
    int                   send_idle_pct = 0;
    int                   recv_stall_pct = 0;
    bit                   hold_req = 1'b0;
    bit                   hold_taken = 1'b0;
    int                   hold_len = 0;
    int                   words_sent = 0;
    int                   cycle_count = 0;

    stream_pattern_censor u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #(CLK_PERIOD/2) i_clk = ~i_clk;

    // Abort a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Count down one long receiver hold-off, started once on request
    always @(posedge i_clk) begin
        if (hold_req && !hold_taken) begin
            hold_taken <= 1'b1;
            hold_len   <= 400;
        end else if (hold_len != 0) begin
            hold_len <= hold_len - 1;
        end
    end

    // Check result words and pick the next ready, honoring a long hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else begin
            if (out_if.valid && out_if.ready) begin
                sb.check_result({out_if.matched, out_if.text_length, out_if.read_char,
                                 out_if.overflow, out_if.bad_index});
            end
            if (hold_len != 0) begin
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    function automatic bit [HASH_W-1:0] pattern_hash_of();
        bit [63:0] h;
        h = 0;
        foreach (pattern_q[i]) begin
            h = (h * BASE_64 + 64'(pattern_q[i])) % MOD_64;
        end
        return h[HASH_W-1:0];
    endfunction

    function automatic bit [HASH_W-1:0] base_power(int n);
        bit [63:0] p;
        p = 1;
        for (int i = 0; i < n; i++) begin
            p = (p * BASE_64) % MOD_64;
        end
        return p[HASH_W-1:0];
    endfunction

    // Append random characters to the pattern
    function automatic void grow_pattern(input int count);
        repeat (count) pattern_q.insert(pattern_q.size(), CHAR_W'($urandom_range(255)));
    endfunction

    // Write a register, then read it back
    task automatic cfg_write(input logic [1:0] reg_idx, input logic [APB_DW-1:0] value);
        logic [APB_DW-1:0] want;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        want = sb.write_reg(reg_idx, value);
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== want) begin
            sb.report("register readback", prdata, want);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic program_pattern();
        cfg_write(REG_PAT_LEN, APB_DW'(pattern_q.size()));
        cfg_write(REG_PAT_HASH, APB_DW'(pattern_hash_of()));
        cfg_write(REG_PAT_POWER, APB_DW'(base_power(pattern_q.size())));
    endtask

    // Offer one word, with random idle cycles ahead of it, until accepted
    task automatic send_word(input logic op, input logic [CHAR_W-1:0] ch,
                             input logic [IDX_W-1:0] idx);
        while ($urandom_range(99) < send_idle_pct) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_if.valid      <= 1'b1;
        in_if.opcode     <= op;
        in_if.text_char  <= ch;
        in_if.read_index <= idx;
        do @(posedge i_clk); while (!in_if.ready);
        sb.note_word(op, ch, idx);
        words_sent++;
    endtask

    task automatic push_char(input logic [CHAR_W-1:0] ch);
        send_word(OP_PUSH, ch, IDX_W'($urandom_range(4095)));
    endtask

    task automatic read_at(input logic [IDX_W-1:0] idx);
        send_word(OP_READ, CHAR_W'($urandom_range(255)), idx);
    endtask

    // Drop valid and hold until every predicted word has arrived
    task automatic wait_drained();
        in_if.valid <= 1'b0;
        do @(posedge i_clk); while (sb.expected_q.size() != 0);
    endtask

    // Mostly whole, nested and broken copies of the pattern, with noise and reads
    task automatic run_text_phase(input int phase_id);
        int first;
        int kind;
        int k;
        int m;
        bit held;
        bit paused;
        first  = words_sent;
        m      = pattern_q.size();
        held   = 1'b0;
        paused = 1'b0;
        while (words_sent - first < TEXT_ITEMS) begin
            if (phase_id == 0 && !held && words_sent - first >= 20) begin
                hold_req <= 1'b1;
                held = 1'b1;
            end
            if (phase_id == 1 && !paused && words_sent - first >= 150) begin
                wait_drained();
                paused = 1'b1;
            end
            kind = $urandom_range(99);
            if (kind < 45) begin
                foreach (pattern_q[i]) push_char(pattern_q[i]);
            end else if (kind < 60 && m > 1) begin
                k = $urandom_range(1, m - 1);
                for (int i = 0; i < k; i++) push_char(pattern_q[i]);
                foreach (pattern_q[i]) push_char(pattern_q[i]);
                for (int i = k; i < m; i++) push_char(pattern_q[i]);
            end else if (kind < 72) begin
                k = $urandom_range(0, m - 1);
                for (int i = 0; i < k; i++) push_char(pattern_q[i]);
                push_char(CHAR_W'($urandom_range(255)));
            end else if (kind < 85) begin
                repeat ($urandom_range(1, 3)) push_char(CHAR_W'($urandom_range(255)));
            end else if (sb.depth > 0 && $urandom_range(99) < 75) begin
                read_at(IDX_W'($urandom_range(sb.depth - 1)));
            end else begin
                read_at(IDX_W'($urandom_range(4095)));
            end
        end
    endtask

    initial begin
        int               send_tbl [4];
        int               recv_tbl [4];

        send_tbl = '{0, 81, 0, 10};
        recv_tbl = '{0, 0, 81, 10};

        // Hold every input at a known value through reset
        i_rst_n          <= 1'b0;
        psel             <= 1'b0;
        penable          <= 1'b0;
        pwrite           <= 1'b0;
        paddr            <= '0;
        pwdata           <= '0;
        in_if.valid      <= 1'b0;
        in_if.opcode     <= OP_PUSH;
        in_if.text_char  <= '0;
        in_if.read_index <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset pattern is a single zero character
        read_at('0);
        push_char(8'h00);
        push_char(8'hFF);
        push_char(8'hA5);
        read_at(12'd0);
        read_at(12'd1);
        read_at(12'd2);
        read_at(12'hFFF);

        // Zero pattern length never compares
        wait_drained();
        cfg_write(REG_PAT_LEN, '0);
        push_char(8'h00);
        read_at(12'd2);

        // Two-character pattern, plain and behind a repeated first character
        wait_drained();
        pattern_q = '{8'h5A, 8'hC3};
        program_pattern();
        push_char(8'h5A);
        push_char(8'hC3);
        push_char(8'h5A);
        push_char(8'h5A);
        push_char(8'hC3);

        // Power written at or above the modulus must act reduced
        wait_drained();
        pattern_q = '{8'h7E};
        program_pattern();
        cfg_write(REG_PAT_POWER, APB_DW'(base_power(1)) + APB_DW'(HASH_MOD));
        push_char(8'h7E);
        push_char(8'h11);
        push_char(8'h7E);

        // Hash at or above the modulus never matches
        wait_drained();
        cfg_write(REG_PAT_HASH, APB_DW'(HASH_MOD));
        push_char(8'h00);
        push_char(8'h7E);
        wait_drained();
        cfg_write(REG_PAT_HASH, 32'h3FFF_FFFF);
        cfg_write(REG_PAT_POWER, '0);
        push_char(8'hFF);

        // Random text under each idling mix, new pattern per phase
        for (int ph = 0; ph < 4; ph++) begin
            wait_drained();
            send_idle_pct  = send_tbl[ph];
            recv_stall_pct = recv_tbl[ph];
            pattern_q.delete();
            case (ph)
                0: grow_pattern($urandom_range(2, 5));
                1: grow_pattern($urandom_range(3, 8));
                2: grow_pattern(1);
                default: grow_pattern($urandom_range(6, 16));
            endcase
            program_pattern();
            run_text_phase(ph);
        end

        // Pattern longer than the stack: never compares, then read back
        wait_drained();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        cfg_write(REG_PAT_LEN, 32'd5000);
        repeat (4) push_char(CHAR_W'($urandom_range(255)));
        read_at(12'hFFF);
        read_at(12'd0);
        repeat (3) read_at(IDX_W'($urandom_range(4095)));

        // Drain, let the pipeline settle, then judge
        wait_drained();
        repeat (64) @(posedge i_clk);
        if (sb.expected_q.size() != 0) begin
            sb.report("words never returned", sb.expected_q.size(), 0);
        end
        if (sb.errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule
